// File: rtl/core/shca_pkg.sv
package shca_pkg;

   // Default depth of the hit store.
   localparam int MAX_HITS_DEFAULT = 32;

   // Command codes carried in the cmd field of an input word.
   localparam logic [1:0] CMD_CLEAR = 2'd0;
   localparam logic [1:0] CMD_ADD   = 2'd1;
   localparam logic [1:0] CMD_CHECK = 2'd2;

   // Register indexes of the configuration port.
   localparam logic REG_THRESHOLD = 1'b0;
   localparam logic REG_DETECTOR  = 1'b1;

   // One stored hit is {time, energy, channel}.
   localparam int ENTRY_W = 64;

   // Output saturation limits and the "none" codes.
   localparam logic [31:0]        CNT_MAX   = 32'd63;
   localparam logic [31:0]        SUM_MAX   = 32'd2097151;
   localparam logic signed [16:0] PEAK_NONE = -17'sd1;
   localparam logic signed [32:0] TIME_NONE = -33'sd100;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic rd_issue;
      logic commit;
   } shca_ctl_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic store_empty;
      logic last_addr;
      logic out_free;
   } shca_sts_type;

endpackage

// File: rtl/core/shca_ram.sv
module shca_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/shca_ctrl.sv
module shca_ctrl
   import shca_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  shca_sts_type sts,
   output shca_ctl_type ctl
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_WALK   = 2'd1;
   localparam logic [1:0] ST_DRAIN  = 2'd2;
   localparam logic [1:0] ST_COMMIT = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in = state_ff;
      ctl      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ctl.load = 1'b1;
               state_in = sts.store_empty ? ST_COMMIT : ST_WALK;
            end
         end
         ST_WALK: begin
            ctl.rd_issue = 1'b1;
            if (sts.last_addr) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // The last entry read is folded in during this cycle.
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (sts.out_free) begin
               ctl.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

// File: rtl/core/shca_datapath.sv
module shca_datapath
   import shca_pkg::*;
#(
   parameter int MAX_HITS = MAX_HITS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  shca_ctl_type        ctl,
   output shca_sts_type        sts,
   input  logic [15:0]         energy_threshold,
   input  logic [3:0]          cluster_detector,
   input  logic [1:0]          req_cmd,
   input  logic [15:0]         req_hit_channel,
   input  logic [3:0]          req_hit_detector,
   input  logic [15:0]         req_hit_energy,
   input  logic [31:0]         req_hit_time,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_in_cluster,
   output logic [5:0]          rsp_hit_count,
   output logic                rsp_overflow,
   output logic [5:0]          rsp_count_above,
   output logic [20:0]         rsp_energy_sum_all,
   output logic [20:0]         rsp_energy_sum_above,
   output logic [15:0]         rsp_peak_energy_all,
   output logic signed [16:0]  rsp_peak_energy_above,
   output logic [15:0]         rsp_peak_channel,
   output logic [15:0]         rsp_lowest_channel,
   output logic [15:0]         rsp_lowest_channel_above,
   output logic signed [32:0]  rsp_earliest_time_above
);

   localparam int ADDR_W = $clog2(MAX_HITS);
   localparam int CNT_W  = $clog2(MAX_HITS + 1);
   localparam int SUM_W  = 16 + CNT_W;

   typedef struct packed {
      logic             seen;
      logic [CNT_W-1:0] cnt_above;
      logic [SUM_W-1:0] sum_all;
      logic [SUM_W-1:0] sum_above;
      logic [15:0]      pk_all;
      logic [15:0]      pk_chan;
      logic [15:0]      low;
      logic [15:0]      low_above;
      logic             have_above;
      logic [15:0]      pk_above;
      logic             have_time;
      logic [31:0]      tmin;
   } acc_type;

   // Folds one hit into the running figures, in store order.
   function automatic acc_type fold(acc_type a, logic [15:0] c, logic [15:0] e,
                                    logic [31:0] t, logic [15:0] thr);
      acc_type r;
      logic    above;
      r       = a;
      above   = (e > thr);
      r.sum_all = a.sum_all + SUM_W'(e);
      if (!a.seen) begin
         r.seen      = 1'b1;
         r.pk_all    = e;
         r.pk_chan   = c;
         r.low       = c;
         r.low_above = c;
      end else begin
         if (e > a.pk_all) begin
            r.pk_all  = e;
            r.pk_chan = c;
         end
         if (c < a.low) begin
            r.low = c;
         end
         if (above && (c < a.low_above)) begin
            r.low_above = c;
         end
      end
      if (above) begin
         r.cnt_above = a.cnt_above + CNT_W'(1);
         r.sum_above = a.sum_above + SUM_W'(e);
         if (!a.have_above || (e > a.pk_above)) begin
            r.have_above = 1'b1;
            r.pk_above   = e;
         end
         if ((t != 32'd0) && (!a.have_time || (t < a.tmin))) begin
            r.have_time = 1'b1;
            r.tmin      = t;
         end
      end
      return r;
   endfunction

   function automatic logic [5:0] sat_cnt(logic [CNT_W-1:0] x);
      return (32'(x) > CNT_MAX) ? 6'(CNT_MAX) : 6'(x);
   endfunction

   function automatic logic [20:0] sat_sum(logic [SUM_W-1:0] x);
      return (32'(x) > SUM_MAX) ? 21'(SUM_MAX) : 21'(x);
   endfunction

   // Current word.
   logic [1:0]  cmd_ff;
   logic [15:0] chan_ff;
   logic [3:0]  det_ff;
   logic [15:0] energy_ff;
   logic [31:0] time_ff;

   // Store bookkeeping and the walk.
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             overflow_ff;
   logic             overflow_in;
   logic [CNT_W-1:0] idx_ff;
   logic             rd_vld_ff;
   logic             member_ff;
   acc_type          acc_ff;

   logic [ENTRY_W-1:0] rd_data;
   logic [15:0]        rd_chan;
   logic [15:0]        rd_energy;
   logic [31:0]        rd_time;
   logic               adjacent;
   logic               do_add;
   acc_type            acc_final;

   // Result register.
   logic rsp_valid_ff;

   shca_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_HITS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ctl.commit && do_add),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data ({time_ff, energy_ff, chan_ff}),
      .rd_en   (ctl.rd_issue),
      .rd_addr (idx_ff[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   assign rd_chan   = rd_data[15:0];
   assign rd_energy = rd_data[31:16];
   assign rd_time   = rd_data[63:32];

   assign adjacent = (det_ff == cluster_detector) &&
                     ((({1'b0, rd_chan} + 17'd1) == {1'b0, chan_ff}) ||
                      (({1'b0, chan_ff} + 17'd1) == {1'b0, rd_chan}));

   assign do_add = (cmd_ff == CMD_ADD) && (32'(count_ff) < 32'(MAX_HITS));

   always_comb begin
      acc_final = acc_ff;
      if (do_add) begin
         acc_final = fold(acc_ff, chan_ff, energy_ff, time_ff, energy_threshold);
      end
   end

   always_comb begin
      count_in    = count_ff;
      overflow_in = overflow_ff;
      if (ctl.commit) begin
         priority if (cmd_ff == CMD_CLEAR) begin
            count_in    = '0;
            overflow_in = 1'b0;
         end else if (do_add) begin
            count_in = count_ff + CNT_W'(1);
         end else if (cmd_ff == CMD_ADD) begin
            overflow_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         overflow_ff  <= 1'b0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff    <= count_in;
         overflow_ff <= overflow_in;
         rd_vld_ff   <= ctl.rd_issue;
         if (ctl.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         cmd_ff    <= req_cmd;
         chan_ff   <= req_hit_channel;
         det_ff    <= req_hit_detector;
         energy_ff <= req_hit_energy;
         time_ff   <= req_hit_time;
         idx_ff    <= '0;
         member_ff <= 1'b0;
         acc_ff    <= '0;
      end else begin
         if (ctl.rd_issue) begin
            idx_ff <= idx_ff + CNT_W'(1);
         end
         if (rd_vld_ff) begin
            if (adjacent) begin
               member_ff <= 1'b1;
            end
            // A clear empties the store, so old entries add nothing to its figures.
            if (cmd_ff != CMD_CLEAR) begin
               acc_ff <= fold(acc_ff, rd_chan, rd_energy, rd_time, energy_threshold);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.commit) begin
         rsp_in_cluster           <= member_ff;
         rsp_hit_count            <= sat_cnt(count_in);
         rsp_overflow             <= overflow_in;
         rsp_count_above          <= sat_cnt(acc_final.cnt_above);
         rsp_energy_sum_all       <= sat_sum(acc_final.sum_all);
         rsp_energy_sum_above     <= sat_sum(acc_final.sum_above);
         rsp_peak_energy_all      <= acc_final.pk_all;
         rsp_peak_energy_above    <= acc_final.have_above ?
                                     $signed({1'b0, acc_final.pk_above}) : PEAK_NONE;
         rsp_peak_channel         <= acc_final.pk_chan;
         rsp_lowest_channel       <= acc_final.low;
         rsp_lowest_channel_above <= acc_final.low_above;
         rsp_earliest_time_above  <= acc_final.have_time ?
                                     $signed({1'b0, acc_final.tmin}) : TIME_NONE;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   assign sts.store_empty = (count_ff == '0);
   assign sts.last_addr   = (idx_ff == (count_ff - CNT_W'(1)));
   assign sts.out_free    = !rsp_valid_ff || !rsp_stall;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= 32'(MAX_HITS))
      else $error("hit store count beyond its depth");

   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      overflow_ff |-> (32'(count_ff) == 32'(MAX_HITS)))
      else $error("overflow flagged while the store has room");

   a_read_in_range: assert property (@(posedge clock) disable iff (reset)
      ctl.rd_issue |-> (idx_ff < count_ff))
      else $error("walk reads past the stored hits");

   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      ctl.commit |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result register overwritten while stalled");

   a_commit_shows: assert property (@(posedge clock) disable iff (reset)
      ctl.commit |=> rsp_valid_ff)
      else $error("committed result not presented");

endmodule

// File: rtl/core/strip_hit_cluster_accumulator.sv
// Strip hit cluster accumulator.
//
// Input channel (req_): one word per hit with a command. A clear empties the
// cluster and its overflow flag, an add stores the hit, and a check stores
// nothing. A word is taken at a clock edge with req_valid high and req_stall
// low. Result channel (rsp_): exactly one word per input word, carrying the
// membership answer taken before the command and the cluster figures after it.
// Configuration (csr_): an APB-style port with the energy threshold at byte
// address 0 and the cluster detector at address 4; write it only while idle.
// With hits stored before a word arrives, the walk reads them from the hit
// memory, one stored entry per cycle through its single read port, then a
// drain step folds in the last entry read and the result is committed to
// the output register; with an empty store the word goes straight to commit.
// The next word is taken only after the current result is registered.
// Reset empties the store, clears overflow and sets both registers to zero.
// While rsp_stall holds a result, the next word is still taken and walked, and
// its result waits in the commit step until the output register frees.
module strip_hit_cluster_accumulator
   import shca_pkg::*;
#(
   parameter int MAX_HITS = MAX_HITS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   // Input channel.
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_cmd,
   input  logic [15:0]        req_hit_channel,
   input  logic [3:0]         req_hit_detector,
   input  logic [15:0]        req_hit_energy,
   input  logic [31:0]        req_hit_time,
   // Result channel.
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_in_cluster,
   output logic [5:0]         rsp_hit_count,
   output logic               rsp_overflow,
   output logic [5:0]         rsp_count_above,
   output logic [20:0]        rsp_energy_sum_all,
   output logic [20:0]        rsp_energy_sum_above,
   output logic [15:0]        rsp_peak_energy_all,
   output logic signed [16:0] rsp_peak_energy_above,
   output logic [15:0]        rsp_peak_channel,
   output logic [15:0]        rsp_lowest_channel,
   output logic [15:0]        rsp_lowest_channel_above,
   output logic signed [32:0] rsp_earliest_time_above,
   // Configuration port.
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [2:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   logic [15:0]  threshold_ff;
   logic [3:0]   detector_ff;
   logic         csr_write;
   logic         csr_index;
   shca_ctl_type ctl;
   shca_sts_type sts;

   // Registers sit on 4-byte boundaries, so bit 2 picks the register.
   assign csr_index  = csr_paddr[2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= '0;
         detector_ff  <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_THRESHOLD: threshold_ff <= csr_pwdata[15:0];
            REG_DETECTOR:  detector_ff  <= csr_pwdata[3:0];
            default:       threshold_ff <= threshold_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_THRESHOLD: csr_prdata = {16'd0, threshold_ff};
         REG_DETECTOR:  csr_prdata = {28'd0, detector_ff};
         default:       csr_prdata = '0;
      endcase
   end

   // The controller sequences accept, walk, drain and commit; the datapath
   // holds the store, the running figures and the result register.
   shca_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .ctl       (ctl)
   );

   shca_datapath #(
      .MAX_HITS (MAX_HITS)
   ) u_datapath (
      .clock                    (clock),
      .reset                    (reset),
      .ctl                      (ctl),
      .sts                      (sts),
      .energy_threshold         (threshold_ff),
      .cluster_detector         (detector_ff),
      .req_cmd                  (req_cmd),
      .req_hit_channel          (req_hit_channel),
      .req_hit_detector         (req_hit_detector),
      .req_hit_energy           (req_hit_energy),
      .req_hit_time             (req_hit_time),
      .rsp_valid                (rsp_valid),
      .rsp_stall                (rsp_stall),
      .rsp_in_cluster           (rsp_in_cluster),
      .rsp_hit_count            (rsp_hit_count),
      .rsp_overflow             (rsp_overflow),
      .rsp_count_above          (rsp_count_above),
      .rsp_energy_sum_all       (rsp_energy_sum_all),
      .rsp_energy_sum_above     (rsp_energy_sum_above),
      .rsp_peak_energy_all      (rsp_peak_energy_all),
      .rsp_peak_energy_above    (rsp_peak_energy_above),
      .rsp_peak_channel         (rsp_peak_channel),
      .rsp_lowest_channel       (rsp_lowest_channel),
      .rsp_lowest_channel_above (rsp_lowest_channel_above),
      .rsp_earliest_time_above  (rsp_earliest_time_above)
   );

endmodule

// File: tb/strip_hit_cluster_accumulator_tb.sv
module strip_hit_cluster_accumulator_tb
   import shca_pkg::*;
;

   timeunit 1ns;
   timeprecision 1ps;

   // The block treats the one spare command code like a membership check.
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   localparam int STORE_DEPTH     = MAX_HITS_DEFAULT;
   localparam int PHASES          = 8;
   localparam int WORDS_PER_PHASE = 80;

   // One input word, as the predictor sees it.
   typedef struct packed {
      logic [1:0]  cmd;
      logic [15:0] channel;
      logic [3:0]  detector;
      logic [15:0] energy;
      logic [31:0] stamp;
   } hit_word_type;

   // One result word. The signed fields are kept as plain bit patterns.
   typedef struct packed {
      logic        in_cluster;
      logic [5:0]  hit_count;
      logic        overflow;
      logic [5:0]  count_above;
      logic [20:0] energy_sum_all;
      logic [20:0] energy_sum_above;
      logic [15:0] peak_energy_all;
      logic [16:0] peak_energy_above;
      logic [15:0] peak_channel;
      logic [15:0] lowest_channel;
      logic [15:0] lowest_channel_above;
      logic [32:0] earliest_time_above;
   } cluster_figures_type;

   // A row of the directed table. Rows marked typed carry their result
   // written out by hand; the rest are checked against the predictor.
   typedef struct packed {
      hit_word_type        word;
      logic                typed;
      cluster_figures_type figures;
   } directed_row_type;

   // The figures of an empty cluster, seen by a word whose hit is no member.
   localparam cluster_figures_type EMPTY_FIGURES = cluster_figures_type'{
      1'b0, 6'd0, 1'b0, 6'd0, 21'd0, 21'd0, 16'd0, PEAK_NONE,
      16'd0, 16'd0, 16'd0, TIME_NONE};

   logic               clock = 1'b0;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [1:0]         req_cmd;
   logic [15:0]        req_hit_channel;
   logic [3:0]         req_hit_detector;
   logic [15:0]        req_hit_energy;
   logic [31:0]        req_hit_time;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic               rsp_in_cluster;
   logic [5:0]         rsp_hit_count;
   logic               rsp_overflow;
   logic [5:0]         rsp_count_above;
   logic [20:0]        rsp_energy_sum_all;
   logic [20:0]        rsp_energy_sum_above;
   logic [15:0]        rsp_peak_energy_all;
   logic signed [16:0] rsp_peak_energy_above;
   logic [15:0]        rsp_peak_channel;
   logic [15:0]        rsp_lowest_channel;
   logic [15:0]        rsp_lowest_channel_above;
   logic signed [32:0] rsp_earliest_time_above;
   logic               csr_psel;
   logic               csr_penable;
   logic               csr_pwrite;
   logic [2:0]         csr_paddr;
   logic [31:0]        csr_pwdata;
   logic [31:0]        csr_prdata;
   logic               csr_pready;

   strip_hit_cluster_accumulator DUT (
      .clock                    (clock),
      .reset                    (reset),
      .req_valid                (req_valid),
      .req_stall                (req_stall),
      .req_cmd                  (req_cmd),
      .req_hit_channel          (req_hit_channel),
      .req_hit_detector         (req_hit_detector),
      .req_hit_energy           (req_hit_energy),
      .req_hit_time             (req_hit_time),
      .rsp_valid                (rsp_valid),
      .rsp_stall                (rsp_stall),
      .rsp_in_cluster           (rsp_in_cluster),
      .rsp_hit_count            (rsp_hit_count),
      .rsp_overflow             (rsp_overflow),
      .rsp_count_above          (rsp_count_above),
      .rsp_energy_sum_all       (rsp_energy_sum_all),
      .rsp_energy_sum_above     (rsp_energy_sum_above),
      .rsp_peak_energy_all      (rsp_peak_energy_all),
      .rsp_peak_energy_above    (rsp_peak_energy_above),
      .rsp_peak_channel         (rsp_peak_channel),
      .rsp_lowest_channel       (rsp_lowest_channel),
      .rsp_lowest_channel_above (rsp_lowest_channel_above),
      .rsp_earliest_time_above  (rsp_earliest_time_above),
      .csr_psel                 (csr_psel),
      .csr_penable              (csr_penable),
      .csr_pwrite               (csr_pwrite),
      .csr_paddr                (csr_paddr),
      .csr_pwdata               (csr_pwdata),
      .csr_prdata               (csr_prdata),
      .csr_pready               (csr_pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // The predictor's own copy of the hit store and of the two registers.
   logic [15:0] hit_chan   [STORE_DEPTH];
   logic [15:0] hit_energy [STORE_DEPTH];
   logic [31:0] hit_stamp  [STORE_DEPTH];
   int          stored_hits;
   logic        store_overflow;
   logic [15:0] cfg_threshold;
   logic [3:0]  cfg_detector;

   // Result words still owed by the block, oldest first.
   cluster_figures_type pending_figures[$];
   directed_row_type    directed_rows[$];
   int                  mismatches;

   // Sender pacing and the shape of the random traffic.
   bit          sender_paced;
   int          burst_left;
   int          clear_pct;
   int          forced_adds;
   logic [15:0] chan_base;

   // Applies one accepted word to the predictor's store and returns the
   // result word the block owes for it. Membership is decided against the
   // store as it was before the command; the figures are taken after it and
   // follow the threshold currently programmed.
   function automatic cluster_figures_type update_cluster(input hit_word_type w);
      cluster_figures_type f;
      logic                member;
      int unsigned         total;
      int unsigned         total_above;
      int unsigned         above;
      int                  best_above;
      logic                have_stamp;
      logic [31:0]         stamp_min;
      member = 1'b0;
      if (w.detector == cfg_detector) begin
         // Adjacency is taken without wrap, so 0 and 65535 are far apart.
         for (int i = 0; i < stored_hits; i++) begin
            if (int'(w.channel) == int'(hit_chan[i]) + 1 ||
                int'(hit_chan[i]) == int'(w.channel) + 1)
               member = 1'b1;
         end
      end
      case (w.cmd)
         CMD_CLEAR: begin
            stored_hits    = 0;
            store_overflow = 1'b0;
         end
         CMD_ADD: begin
            if (stored_hits >= STORE_DEPTH) begin
               store_overflow = 1'b1;
            end else begin
               hit_chan[stored_hits]   = w.channel;
               hit_energy[stored_hits] = w.energy;
               hit_stamp[stored_hits]  = w.stamp;
               stored_hits++;
            end
         end
         default: ;
      endcase

      f = EMPTY_FIGURES;
      f.in_cluster = member;
      f.overflow   = store_overflow;
      total        = 0;
      total_above  = 0;
      above        = 0;
      best_above   = -1;
      have_stamp   = 1'b0;
      stamp_min    = '0;
      if (stored_hits > 0) begin
         f.peak_energy_all      = hit_energy[0];
         f.peak_channel         = hit_chan[0];
         f.lowest_channel       = hit_chan[0];
         f.lowest_channel_above = hit_chan[0];
      end
      for (int i = 0; i < stored_hits; i++) begin
         total += hit_energy[i];
         // Strictly larger only, so the first of equal peaks keeps its channel.
         if (hit_energy[i] > f.peak_energy_all) begin
            f.peak_energy_all = hit_energy[i];
            f.peak_channel    = hit_chan[i];
         end
         if (hit_chan[i] < f.lowest_channel)
            f.lowest_channel = hit_chan[i];
         if (hit_energy[i] > cfg_threshold) begin
            above++;
            total_above += hit_energy[i];
            if (int'(hit_energy[i]) > best_above)
               best_above = int'(hit_energy[i]);
            if (hit_chan[i] < f.lowest_channel_above)
               f.lowest_channel_above = hit_chan[i];
            // A zero timestamp means no time at all and never wins.
            if (hit_stamp[i] != 0 && (!have_stamp || hit_stamp[i] < stamp_min)) begin
               stamp_min  = hit_stamp[i];
               have_stamp = 1'b1;
            end
         end
      end
      f.hit_count        = (stored_hits > CNT_MAX) ? CNT_MAX[5:0] : 6'(stored_hits);
      f.count_above      = (above > CNT_MAX) ? CNT_MAX[5:0] : above[5:0];
      f.energy_sum_all   = (total > SUM_MAX) ? SUM_MAX[20:0] : total[20:0];
      f.energy_sum_above = (total_above > SUM_MAX) ? SUM_MAX[20:0] : total_above[20:0];
      if (best_above >= 0)
         f.peak_energy_above = 17'(best_above);
      if (have_stamp)
         f.earliest_time_above = {1'b0, stamp_min};
      return f;
   endfunction

   function automatic void check_field(input string name, input logic [32:0] want,
                                       input logic [32:0] got);
      if (got !== want) begin
         $error("%s: expected %h, got %h", name, want, got);
         mismatches++;
      end
   endfunction

   // Draws the next random word. Most words build clusters the way a
   // detector would: runs of adds on neighboring channels of the cluster's
   // own detector, with energies close to the threshold, and membership
   // checks aimed next to hits already stored. The rest is clears and noise.
   function automatic hit_word_type random_hit();
      hit_word_type w;
      int           pick;
      w.cmd      = CMD_CHECK;
      w.channel  = 16'($urandom);
      w.detector = 4'($urandom_range(0, 15));
      w.energy   = 16'($urandom);
      w.stamp    = $urandom;
      pick       = $urandom_range(0, 99);
      if (forced_adds > 0) begin
         forced_adds--;
         pick = 99;
      end
      if (pick < 5) begin
         // Noise: any command, including the spare code, with any fields.
         w.cmd = 2'($urandom_range(0, 3));
      end else if (pick < 5 + clear_pct) begin
         w.cmd = CMD_CLEAR;
         case ($urandom_range(0, 3))
            0:       chan_base = 16'h0000;
            1:       chan_base = 16'hFFFF;
            default: chan_base = 16'($urandom);
         endcase
      end else if (pick < 45) begin
         w.cmd = ($urandom_range(0, 19) == 0) ? CMD_UNUSED : CMD_CHECK;
         if (stored_hits > 0 && $urandom_range(0, 3) != 0)
            w.channel = hit_chan[$urandom_range(0, stored_hits - 1)]
                        + 16'($urandom_range(0, 4)) - 16'd2;
         if ($urandom_range(0, 4) != 0)
            w.detector = cfg_detector;
      end else begin
         w.cmd     = CMD_ADD;
         w.channel = chan_base + 16'($urandom_range(0, 6)) - 16'd3;
         chan_base = w.channel;
         if ($urandom_range(0, 7) != 0)
            w.detector = cfg_detector;
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: w.energy = cfg_threshold + 16'($urandom_range(0, 2)) - 16'd1;
            5, 6:          w.energy = 16'($urandom_range(0, 4095));
            default:       ;
         endcase
         case ($urandom_range(0, 3))
            0:       w.stamp = 32'd0;
            1:       w.stamp = $urandom_range(1, 20);
            default: ;
         endcase
      end
      return w;
   endfunction

   function automatic void add_row(input hit_word_type w, input logic typed,
                                   input cluster_figures_type f);
      directed_rows.push_back(directed_row_type'{w, typed, f});
   endfunction

   // Offers one word to the block and, once it is taken, queues the result
   // word it owes. In paced mode the sender works in bursts separated by
   // gaps of random length, short ones mostly and now and then long enough
   // to let the block run dry.
   task automatic send_word(input hit_word_type w, input logic typed,
                            input cluster_figures_type typed_figures);
      cluster_figures_type figures;
      if (sender_paced) begin
         if (burst_left == 0) begin
            req_valid <= 1'b0;
            repeat (($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : $urandom_range(5, 45))
               @(posedge clock);
            burst_left = $urandom_range(1, 16);
         end
         burst_left--;
      end
      req_valid        <= 1'b1;
      req_cmd          <= w.cmd;
      req_hit_channel  <= w.channel;
      req_hit_detector <= w.detector;
      req_hit_energy   <= w.energy;
      req_hit_time     <= w.stamp;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      figures = update_cluster(w);
      pending_figures.push_back(typed ? typed_figures : figures);
   endtask

   // Holds the sender back until every owed result word has come out, then
   // lets the block settle for the length of its longest walk.
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_figures.size() != 0)
         @(posedge clock);
      repeat (STORE_DEPTH + 4)
         @(posedge clock);
   endtask

   // Writes one register with a setup and an access cycle, then reads it
   // back the same way. The predictor takes the new value once the write
   // edge has passed.
   task automatic csr_write(input logic reg_index, input logic [31:0] value);
      logic [31:0] want;
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= {reg_index, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready)
         @(posedge clock);
      if (reg_index == REG_THRESHOLD) begin
         cfg_threshold = value[15:0];
         want          = {16'd0, cfg_threshold};
      end else begin
         cfg_detector = value[3:0];
         want         = {28'd0, cfg_detector};
      end
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready)
         @(posedge clock);
      check_field("csr_prdata", 33'(want), 33'(csr_prdata));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Result side: every word taken off the output is compared field by field
   // with the oldest owed word. The same block drives rsp_stall through
   // stretches of its own: free flow, random stalls, and solid holds.
   int stall_mode;
   int stall_left;

   always @(posedge clock) begin : result_check
      cluster_figures_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_figures.size() == 0) begin
            $error("result word arrived with none outstanding");
            mismatches++;
         end else begin
            want = pending_figures.pop_front();
            check_field("in_cluster", 33'(want.in_cluster), 33'(rsp_in_cluster));
            check_field("hit_count", 33'(want.hit_count), 33'(rsp_hit_count));
            check_field("overflow", 33'(want.overflow), 33'(rsp_overflow));
            check_field("count_above", 33'(want.count_above), 33'(rsp_count_above));
            check_field("energy_sum_all", 33'(want.energy_sum_all),
                        33'(rsp_energy_sum_all));
            check_field("energy_sum_above", 33'(want.energy_sum_above),
                        33'(rsp_energy_sum_above));
            check_field("peak_energy_all", 33'(want.peak_energy_all),
                        33'(rsp_peak_energy_all));
            check_field("peak_energy_above", 33'(want.peak_energy_above),
                        33'(rsp_peak_energy_above[16:0]));
            check_field("peak_channel", 33'(want.peak_channel), 33'(rsp_peak_channel));
            check_field("lowest_channel", 33'(want.lowest_channel),
                        33'(rsp_lowest_channel));
            check_field("lowest_channel_above", 33'(want.lowest_channel_above),
                        33'(rsp_lowest_channel_above));
            check_field("earliest_time_above", want.earliest_time_above,
                        rsp_earliest_time_above[32:0]);
         end
      end
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 2);
         stall_left = (stall_mode == 2) ? $urandom_range(1, 50) : $urandom_range(10, 120);
      end
      stall_left--;
      case (stall_mode)
         1:       rsp_stall <= ($urandom_range(0, 99) < 40);
         2:       rsp_stall <= 1'b1;
         default: rsp_stall <= 1'b0;
      endcase
   end

   // The watchdog leaves a wide margin over the slowest correct run before
   // the run is declared hung.
   initial begin : watchdog
      #(8_000_000);
      $display("** strip_hit_cluster_accumulator: FAILED **");
      $finish;
   end

   initial begin : stimulus
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_cmd          <= CMD_CLEAR;
      req_hit_channel  <= '0;
      req_hit_detector <= '0;
      req_hit_energy   <= '0;
      req_hit_time     <= '0;
      csr_psel         <= 1'b0;
      csr_penable      <= 1'b0;
      csr_pwrite       <= 1'b0;
      csr_paddr        <= '0;
      csr_pwdata       <= '0;
      stored_hits      = 0;
      store_overflow   = 1'b0;
      cfg_threshold    = '0;
      cfg_detector     = '0;
      mismatches       = 0;
      burst_left       = 0;
      clear_pct        = 4;
      forced_adds      = 0;
      chan_base        = 16'h0000;

      // Directed table, run with both registers at zero. A check right
      // after reset sees an empty cluster. The first add uses every field at
      // its top value. Checks then probe the edge of the channel range,
      // where 0 and 65535 must not count as neighbors, a wrong detector, a
      // zero energy that sits on a zero threshold, the spare command, two
      // equal peaks where the first must keep its channel, hits with and
      // without timestamps, alternating bit patterns, and clears that keep
      // the registers.
      add_row(hit_word_type'{CMD_CHECK, 16'h0000, 4'h0, 16'h0000, 32'h0}, 1'b1, EMPTY_FIGURES);
      add_row(hit_word_type'{CMD_ADD, 16'hFFFF, 4'hF, 16'hFFFF, 32'hFFFF_FFFF}, 1'b1,
              cluster_figures_type'{1'b0, 6'd1, 1'b0, 6'd1, 21'd65535, 21'd65535, 16'hFFFF,
                                    17'd65535, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                    33'h0_FFFF_FFFF});
      add_row(hit_word_type'{CMD_CHECK, 16'h0000, 4'h0, 16'h0000, 32'h0}, 1'b0, EMPTY_FIGURES);
      add_row(hit_word_type'{CMD_CHECK, 16'hFFFE, 4'h0, 16'h0000, 32'h0}, 1'b0, EMPTY_FIGURES);
      add_row(hit_word_type'{CMD_CHECK, 16'hFFFE, 4'hF, 16'h0000, 32'h0}, 1'b0, EMPTY_FIGURES);
      add_row(hit_word_type'{CMD_ADD, 16'h0000, 4'h0, 16'h0000, 32'h0}, 1'b0, EMPTY_FIGURES);
      add_row(hit_word_type'{CMD_CHECK, 16'h0001, 4'h0, 16'h0000, 32'h0}, 1'b0, EMPTY_FIGURES);
      add_row(hit_word_type'{CMD_UNUSED, 16'hFFFF, 4'h0, 16'hFFFF, 32'h1}, 1'b0,
              EMPTY_FIGURES);
      add_row(hit_word_type'{CMD_ADD, 16'd100, 4'h5, 16'd1, 32'h0}, 1'b0, EMPTY_FIGURES);
      add_row(hit_word_type'{CMD_ADD, 16'd50, 4'h5, 16'hFFFF, 32'd7}, 1'b0, EMPTY_FIGURES);
      add_row(hit_word_type'{CMD_ADD, 16'd51, 4'h0, 16'd200, 32'd3}, 1'b0, EMPTY_FIGURES);
      add_row(hit_word_type'{CMD_CLEAR, 16'h1234, 4'h3, 16'h0000, 32'h0}, 1'b1, EMPTY_FIGURES);
      add_row(hit_word_type'{CMD_ADD, 16'h5555, 4'h5, 16'hAAAA, 32'hAAAA_AAAA}, 1'b0,
              EMPTY_FIGURES);
      add_row(hit_word_type'{CMD_ADD, 16'hAAAA, 4'hA, 16'h5555, 32'h5555_5555}, 1'b0,
              EMPTY_FIGURES);
      add_row(hit_word_type'{CMD_CHECK, 16'h5556, 4'h0, 16'h0000, 32'h0}, 1'b0, EMPTY_FIGURES);
      add_row(hit_word_type'{CMD_UNUSED, 16'hAAA9, 4'h0, 16'h0000, 32'h0}, 1'b0,
              EMPTY_FIGURES);
      add_row(hit_word_type'{CMD_CLEAR, 16'hFFFF, 4'hF, 16'hFFFF, 32'hFFFF_FFFF}, 1'b1,
              EMPTY_FIGURES);

      repeat (12)
         @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      csr_write(REG_THRESHOLD, 32'd0);
      csr_write(REG_DETECTOR, 32'd0);
      sender_paced = 1'b1;
      foreach (directed_rows[r])
         send_word(directed_rows[r].word, directed_rows[r].typed, directed_rows[r].figures);
      drain();

      // Random phases. The registers change between phases while the store
      // keeps its hits, so the first words of a phase also show the figures
      // following a new threshold. Odd phases open with a clear and a run of
      // adds long enough to fill the store and overflow it. One phase runs
      // the sender without gaps.
      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: begin
               csr_write(REG_THRESHOLD, 32'd65535);
               csr_write(REG_DETECTOR, 32'd15);
            end
            1: begin
               csr_write(REG_THRESHOLD, 32'd0);
               csr_write(REG_DETECTOR, 32'd15);
            end
            2: begin
               csr_write(REG_THRESHOLD, 32'd1);
               csr_write(REG_DETECTOR, 32'd0);
            end
            default: begin
               csr_write(REG_THRESHOLD,
                         (ph % 2 == 1) ? $urandom_range(0, 1000) : $urandom_range(0, 65535));
               csr_write(REG_DETECTOR, $urandom_range(0, 15));
            end
         endcase
         sender_paced = (ph != 2);
         clear_pct    = $urandom_range(1, 8);
         if (ph % 2 == 1) begin
            send_word(hit_word_type'{CMD_CLEAR, 16'($urandom), 4'($urandom_range(0, 15)),
                                     16'($urandom), $urandom}, 1'b0, EMPTY_FIGURES);
            forced_adds = STORE_DEPTH + 2;
         end
         for (int k = 0; k < WORDS_PER_PHASE; k++) begin
            send_word(random_hit(), 1'b0, EMPTY_FIGURES);
            if ($urandom_range(0, 99) == 0)
               drain();
         end
         drain();
      end

      if (mismatches == 0) begin
         $display("** strip_hit_cluster_accumulator: PASSED **");
      end else begin
         $display("** strip_hit_cluster_accumulator: FAILED **");
      end
      $finish;
   end

endmodule

// File: strip_hit_cluster_accumulator.f
rtl/core/shca_pkg.sv
rtl/core/shca_ram.sv
rtl/core/shca_ctrl.sv
rtl/core/shca_datapath.sv
rtl/core/strip_hit_cluster_accumulator.sv
tb/strip_hit_cluster_accumulator_tb.sv
